>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A clocked implication built on the macro above.
`define ASSERT_IMPLY(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

>>> rtl/rgb2hsv_pkg.sv
// Types and constants shared by the RGB to HSV converter modules.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int QUO_W       = FRAC_BITS;
	localparam int DIV_W       = 11;
	localparam int SAT_NUM_W   = 8 + FRAC_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS-1:0] saturation;
		logic [7:0]           brightness;
		logic [7:0]           alpha_out;
	} hsv_t;

	typedef struct packed {
		logic [DIV_W-1:0]     hue_num;
		logic [DIV_W-1:0]     hue_den;
		logic [SAT_NUM_W-1:0] sat_num;
		logic [7:0]           sat_den;
		logic [7:0]           brightness;
		logic [7:0]           alpha;
	} work_t;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage

>>> rtl/rgb2hsv_queue.sv
// Short queue that parts the classifying front end from the divider back end.
`timescale 1ns / 1ps

module rgb2hsv_queue
	import rgb2hsv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t wdata,
	output logic  full,
	input  logic  pop,
	output work_t rdata,
	output logic  empty
);

	work_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rgb2hsv_div.sv
// Pipelined restoring divider that retires one quotient bit per stage.
`timescale 1ns / 1ps

module rgb2hsv_div
	import rgb2hsv_pkg::*;
(
	input  logic             clk,
	input  logic [DIV_W-1:0] num_hi,
	input  logic [QUO_W-1:0] num_lo,
	input  logic [DIV_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	// The upper part of the dividend is always below the divisor, so the
	// quotient fits in QUO_W bits and each partial remainder fits in DIV_W bits.
	logic [DIV_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] acc_s [QUO_W];
	logic [DIV_W-1:0] den_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : gen_step
		logic [DIV_W-1:0] rem_in;
		logic [QUO_W-1:0] acc_in;
		logic [DIV_W-1:0] den_in;
		logic [DIV_W:0]   trial;

		if (k == 0) begin : gen_first
			assign rem_in = num_hi;
			assign acc_in = num_lo;
			assign den_in = den;
		end else begin : gen_next
			assign rem_in = rem_s[k-1];
			assign acc_in = acc_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = {rem_in, acc_in[QUO_W-1]};

		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_in}) begin
				rem_s[k] <= DIV_W'(trial - {1'b0, den_in});
				acc_s[k] <= {acc_in[QUO_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= trial[DIV_W-1:0];
				acc_s[k] <= {acc_in[QUO_W-2:0], 1'b0};
			end
			den_s[k] <= den_in;
		end
	end

	assign quo = acc_s[QUO_W-1];

endmodule

>>> rtl/rgb2hsv_front.sv
// Front end: accepts pixels, finds the largest channel and forms the dividends.
`timescale 1ns / 1ps

module rgb2hsv_front
	import rgb2hsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  pixel_t pixel,
	output logic   busy,
	output logic   push,
	output work_t  work,
	input  logic   full
);

	logic [7:0]       mx;
	logic [7:0]       mn;
	logic [7:0]       delta;
	logic [DIV_W-1:0] six_d;
	logic [DIV_W-1:0] num;
	sector_t          sector;
	work_t            work_d;
	work_t            work_s1;
	logic             valid_s1;
	logic             take;

	always_comb begin
		mx = pixel.red;
		if (pixel.green > mx) begin
			mx = pixel.green;
		end
		if (pixel.blue > mx) begin
			mx = pixel.blue;
		end
		mn = pixel.red;
		if (pixel.green < mn) begin
			mn = pixel.green;
		end
		if (pixel.blue < mn) begin
			mn = pixel.blue;
		end
		delta = mx - mn;
		six_d = DIV_W'({delta, 2'b00}) + DIV_W'({delta, 1'b0});

		if (mx == pixel.red) begin
			sector = SECT_RED;
		end else if (mx == pixel.green) begin
			sector = SECT_GREEN;
		end else begin
			sector = SECT_BLUE;
		end

		unique case (sector)
			SECT_RED: begin
				if (pixel.green >= pixel.blue) begin
					num = DIV_W'(pixel.green - pixel.blue);
				end else begin
					num = six_d - DIV_W'(pixel.blue - pixel.green);
				end
			end
			SECT_GREEN: begin
				num = DIV_W'({delta, 1'b0}) + DIV_W'(pixel.blue) - DIV_W'(pixel.red);
			end
			SECT_BLUE: begin
				num = DIV_W'({delta, 2'b00}) + DIV_W'(pixel.red) - DIV_W'(pixel.green);
			end
			default: begin
				num = '0;
			end
		endcase

		// A gray pixel divides zero by one, which gives a hue of zero.
		if (delta == '0) begin
			work_d.hue_num = '0;
			work_d.hue_den = DIV_W'(1);
		end else begin
			work_d.hue_num = num;
			work_d.hue_den = six_d;
		end
		work_d.sat_num    = {delta, {FRAC_BITS{1'b0}}} - SAT_NUM_W'(delta);
		work_d.sat_den    = (mx == '0) ? 8'd1 : mx;
		work_d.brightness = mx;
		work_d.alpha      = pixel.alpha;
	end

	assign busy = valid_s1 && full;
	assign take = start && !busy;
	assign push = valid_s1;
	assign work = work_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1 <= work_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && full);
		end
	end

endmodule

>>> rtl/rgb2hsv_back.sv
// Back end: divides for hue and saturation and carries brightness and alpha alongside.
`timescale 1ns / 1ps

module rgb2hsv_back
	import rgb2hsv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	input  work_t work,
	output logic  done,
	output hsv_t  hsv
);

	logic [QUO_W-1:0] vld_q;
	logic [7:0]       bright_s [QUO_W];
	logic [7:0]       alpha_s  [QUO_W];
	logic [QUO_W-1:0] hue_quo;
	logic [QUO_W-1:0] sat_quo;

	rgb2hsv_div u_hue_div (
		.clk    (clk),
		.num_hi (work.hue_num),
		.num_lo ('0),
		.den    (work.hue_den),
		.quo    (hue_quo)
	);

	rgb2hsv_div u_sat_div (
		.clk    (clk),
		.num_hi (DIV_W'(work.sat_num[SAT_NUM_W-1:FRAC_BITS])),
		.num_lo (work.sat_num[FRAC_BITS-1:0]),
		.den    (DIV_W'(work.sat_den)),
		.quo    (sat_quo)
	);

	always_ff @(posedge clk) begin
		bright_s[0] <= work.brightness;
		alpha_s[0]  <= work.alpha;
		for (int k = 1; k < QUO_W; k++) begin
			bright_s[k] <= bright_s[k-1];
			alpha_s[k]  <= alpha_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[QUO_W-2:0], valid};
		end
	end

	assign done           = vld_q[QUO_W-1];
	assign hsv.hue        = hue_quo;
	assign hsv.saturation = sat_quo;
	assign hsv.brightness = bright_s[QUO_W-1];
	assign hsv.alpha_out  = alpha_s[QUO_W-1];

endmodule

>>> rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, queue and divider back end.
// A pixel taken at a clock edge passes through one front register, one queue
// stage and sixteen divider stages, then leaves with done high.
// Throughput is one pixel per clock while busy is low; the divider pipelines accept every cycle.
// Reset clears the valid flags and the queue; no pixel is in flight afterward.
`timescale 1ns / 1ps

module rgb_to_hsv_converter
	import rgb2hsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  pixel_t pixel,
	output logic   busy,
	output logic   done,
	output hsv_t   hsv
);

	logic  push;
	logic  full;
	logic  empty;
	work_t front_work;
	work_t queue_work;

	rgb2hsv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pixel  (pixel),
		.busy   (busy),
		.push   (push),
		.work   (front_work),
		.full   (full)
	);

	rgb2hsv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_work),
		.full   (full),
		.pop    (!empty),
		.rdata  (queue_work),
		.empty  (empty)
	);

	rgb2hsv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (!empty),
		.work   (queue_work),
		.done   (done),
		.hsv    (hsv)
	);

endmodule

>>> rtl/rgb2hsv_checker.sv
// Port-level checker for the RGB to HSV converter and its bind statement.
`include "assert_macros.svh"
`timescale 1ns / 1ps

module rgb2hsv_checker
	import rgb2hsv_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input pixel_t pixel,
	input logic   busy,
	input logic   done,
	input hsv_t   hsv
);

	localparam int LATENCY = 18;

	`ASSERT_IMPLY(a_done_has_item, done, $past(start && !busy, LATENCY), "result without an item")
	`ASSERT_IMPLY(a_alpha_kept, done, hsv.alpha_out == $past(pixel.alpha, LATENCY), "alpha changed")
	`ASSERT_IMPLY(a_black_zero, done && (hsv.brightness == '0), (hsv.saturation == '0) && (hsv.hue == '0), "black pixel not zero")
	`ASSERT_IMPLY(a_gray_hue, done && (hsv.saturation == '0), hsv.hue == '0, "gray pixel has hue")
	`ASSERT_IMPLY(a_bright_max, done, (hsv.brightness >= $past(pixel.red, LATENCY)) && (hsv.brightness >= $past(pixel.green, LATENCY)) && (hsv.brightness >= $past(pixel.blue, LATENCY)), "value below a channel")

endmodule

bind rgb_to_hsv_converter rgb2hsv_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.pixel  (pixel),
	.busy   (busy),
	.done   (done),
	.hsv    (hsv)
);
